// File: rtl/stl_pkg.sv
// Package with the widths, token kinds and keyword table of the script token lexer.
`timescale 1ns / 1ps
package stl_pkg;
    localparam int OFFSET_BITS = 32;
    localparam int LENGTH_BITS = 16;
    localparam int LINE_BITS   = 24;
    localparam int KW_COUNT    = 11;

    localparam logic [5:0] K_END = 6'd0, K_ERR = 6'd1, K_COMMENT = 6'd2, K_NAME = 6'd3;
    localparam logic [5:0] K_DEC = 6'd4, K_STR = 6'd5, K_LT = 6'd6, K_LE = 6'd7;
    localparam logic [5:0] K_GT = 6'd8, K_GE = 6'd9, K_NOT = 6'd10, K_NE = 6'd11;
    localparam logic [5:0] K_EQEQ = 6'd12, K_OR = 6'd13, K_AND = 6'd14;
    localparam logic [5:0] K_LPAREN = 6'd15, K_RPAREN = 6'd16, K_LBRACE = 6'd17;
    localparam logic [5:0] K_RBRACE = 6'd18, K_LBRACK = 6'd19, K_RBRACK = 6'd20;
    localparam logic [5:0] K_KW0 = 6'd21, K_LABEL = 6'd32, K_INT = 6'd33;
    localparam logic [5:0] K_ADD = 6'd34, K_ADDA = 6'd35, K_SUB = 6'd36, K_SUBA = 6'd37;
    localparam logic [5:0] K_MUL = 6'd38, K_MULA = 6'd39, K_DIV = 6'd40, K_DIVA = 6'd41;
    localparam logic [5:0] K_MOD = 6'd42, K_MODA = 6'd43, K_ASSIGN = 6'd44, K_SEMI = 6'd45;

    typedef struct packed {
        logic [5:0]             kind;
        logic [OFFSET_BITS-1:0] start_offset;
        logic [LENGTH_BITS-1:0] token_length;
        logic [LINE_BITS-1:0]   line_number;
        logic                   final_item;
    } token_t;

    // Keyword text is right-aligned: the first character sits in the highest used byte.
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'("class"), 64'("function"), 64'("var"), 64'("return"), 64'("if"),
        64'("this"), 64'("while"), 64'("do"), 64'("public"), 64'("private"),
        64'("protect")
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd5, 4'd8, 4'd3, 4'd6, 4'd2, 4'd4, 4'd5, 4'd2, 4'd6, 4'd7, 4'd7
    };

    function automatic logic kw_match(input int k, input logic [LENGTH_BITS-1:0] pos,
                                      input logic [7:0] c);
        logic [7:0] want;
        int         sh;
        sh = 0;
        want = 8'd0;
        if (pos >= LENGTH_BITS'(KW_LEN[k])) begin
            return 1'b0;
        end
        sh = 8 * (int'(KW_LEN[k]) - 1 - int'(pos));
        want = KW_TEXT[k][sh +: 8];
        return want == c;
    endfunction
endpackage

// File: rtl/script_token_lexer.sv
// Top level of the script token lexer: byte scanner and result queue.
//
// The lexer takes one script byte per transfer and reports tokens with kind, start offset,
// length and line. Each byte is scanned in the cycle it is taken; its zero to three results
// go into a four-entry result queue that is read one transfer per cycle while m_tready is
// high. A byte is taken in any cycle where the queue holds at most one result, so ordinary
// text runs at one byte per cycle while the sink keeps up; a byte that yields several
// results (a token, a bracket and the end marker) costs the extra cycles needed to drain them.
`timescale 1ns / 1ps
module script_token_lexer
    import stl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch [7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // kind [5:0], start_offset [37:6], token_length [53:38],
                                   // line_number [77:54], zero [79:78]
    output logic        m_tlast    // final_item
);
    typedef enum logic [4:0] {
        M_IDLE, M_SLASH, M_LCOM, M_BCOM, M_BSTAR, M_DOLLAR, M_NAME, M_WORD,
        M_DIGITS, M_FRAC, M_STR, M_LT, M_GT, M_BANG, M_EQ, M_BAR, M_AMP,
        M_PLUS, M_MINUS, M_STAR, M_PCT
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next, tstart_reg, tstart_next;
    logic [LENGTH_BITS-1:0] tlen_reg, tlen_next;
    logic [LINE_BITS-1:0]   line_reg, line_next, tline_reg, tline_next;
    logic [KW_COUNT-1:0]    hits_reg, hits_next;
    logic                   bslash_reg, bslash_next, halted_reg, halted_next;

    token_t     res [3];
    logic [1:0] res_cnt;
    logic       consumed, found;
    logic [5:0] wkind;
    logic [7:0] c;
    logic       acc, pop;

    token_t     q_reg [4];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg;

    assign c        = s_tdata;
    assign s_tready = cnt_reg <= 3'd1;
    assign acc      = s_tvalid && s_tready;
    assign m_tvalid = cnt_reg != 3'd0;
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = {2'b00, q_reg[rd_reg].line_number, q_reg[rd_reg].token_length,
                       q_reg[rd_reg].start_offset, q_reg[rd_reg].kind};
    assign m_tlast  = q_reg[rd_reg].final_item;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction
    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    always_comb begin
        mode_next   = mode_reg;
        offset_next = offset_reg;
        tstart_next = tstart_reg;
        tlen_next   = tlen_reg;
        line_next   = line_reg;
        tline_next  = tline_reg;
        hits_next   = hits_reg;
        bslash_next = bslash_reg;
        halted_next = halted_reg;
        res_cnt     = 2'd0;
        consumed    = 1'b1;
        found       = 1'b0;
        wkind       = K_LABEL;
        for (int i = 0; i < 3; i++) begin
            res[i] = '0;
        end

        for (int k = 0; k < KW_COUNT; k++) begin
            if (!found && hits_reg[k] && LENGTH_BITS'(KW_LEN[k]) == tlen_reg) begin
                found = 1'b1;
                wkind = K_KW0 + 6'(k);
            end
        end

        if (halted_reg) begin
            consumed = 1'b1;
        end else begin
            // Feed the byte to the pending token.
            unique case (mode_reg)
                M_SLASH: begin
                    if (c == "*" || c == "/") begin
                        if (tlen_next != '1) tlen_next = tlen_next + 1'b1;
                        mode_next = (c == "*") ? M_BCOM : M_LCOM;
                    end else if (c == "=") begin
                        if (tlen_next != '1) tlen_next = tlen_next + 1'b1;
                        res[0] = '{K_DIVA, tstart_reg, tlen_next, tline_reg, 1'b0};
                        res_cnt = 2'd1; mode_next = M_IDLE;
                    end else begin
                        res[0] = '{K_DIV, tstart_reg, tlen_reg, tline_reg, 1'b0};
                        res_cnt = 2'd1; mode_next = M_IDLE; consumed = 1'b0;
                    end
                end
                M_LCOM: begin
                    if (tlen_next != '1) tlen_next = tlen_next + 1'b1;
                    if (c == 8'h0A) begin
                        res[0] = '{K_COMMENT, tstart_reg, tlen_next, tline_reg, 1'b0};
                        res_cnt = 2'd1; mode_next = M_IDLE;
                    end
                end
                M_BCOM: begin
                    if (tlen_next != '1) tlen_next = tlen_next + 1'b1;
                    if (c == "*") mode_next = M_BSTAR;
                end
                M_BSTAR: begin
                    if (tlen_next != '1) tlen_next = tlen_next + 1'b1;
                    if (c == "/") begin
                        res[0] = '{K_COMMENT, tstart_reg, tlen_next, tline_reg, 1'b0};
                        res_cnt = 2'd1; mode_next = M_IDLE;
                    end else if (c != "*") begin
                        mode_next = M_BCOM;
                    end
                end
                M_DOLLAR, M_BAR, M_AMP: begin
                    if ((mode_reg == M_DOLLAR && (is_alpha(c) || c == "_")) ||
                        (mode_reg == M_BAR && c == "|") || (mode_reg == M_AMP && c == "&")) begin
                        if (tlen_next != '1) tlen_next = tlen_next + 1'b1;
                        if (mode_reg == M_DOLLAR) begin
                            mode_next = M_NAME;
                        end else begin
                            res[0] = '{(mode_reg == M_BAR) ? K_OR : K_AND, tstart_reg,
                                       tlen_next, tline_reg, 1'b0};
                            res_cnt = 2'd1; mode_next = M_IDLE;
                        end
                    end else begin
                        res[0] = '{K_ERR, tstart_reg, '0, tline_reg, 1'b1};
                        res_cnt = 2'd1; halted_next = 1'b1; mode_next = M_IDLE;
                    end
                end
                M_NAME, M_WORD: begin
                    if (is_alpha(c) || is_digit(c) || c == "_") begin
                        if (mode_reg == M_WORD) begin
                            for (int k = 0; k < KW_COUNT; k++) begin
                                if (!kw_match(k, tlen_reg, c)) hits_next[k] = 1'b0;
                            end
                        end
                        if (tlen_next != '1) tlen_next = tlen_next + 1'b1;
                    end else begin
                        res[0] = '{(mode_reg == M_NAME) ? K_NAME : wkind, tstart_reg, tlen_reg,
                                   tline_reg, 1'b0};
                        res_cnt = 2'd1; mode_next = M_IDLE; consumed = 1'b0;
                    end
                end
                M_DIGITS, M_FRAC: begin
                    if (is_digit(c) || (mode_reg == M_DIGITS && c == ".")) begin
                        if (tlen_next != '1) tlen_next = tlen_next + 1'b1;
                        if (c == ".") mode_next = M_FRAC;
                    end else begin
                        res[0] = '{(mode_reg == M_DIGITS) ? K_INT : K_DEC, tstart_reg, tlen_reg,
                                   tline_reg, 1'b0};
                        res_cnt = 2'd1; mode_next = M_IDLE; consumed = 1'b0;
                    end
                end
                M_STR: begin
                    if (tlen_next != '1) tlen_next = tlen_next + 1'b1;
                    if (c == 8'h22 && !bslash_reg) begin
                        res[0] = '{K_STR, tstart_reg, tlen_next, tline_reg, 1'b0};
                        res_cnt = 2'd1; mode_next = M_IDLE;
                    end else begin
                        bslash_next = (c == 8'h5C);
                    end
                end
                M_LT, M_GT, M_BANG, M_EQ, M_PLUS, M_MINUS, M_STAR, M_PCT: begin
                    // One-character operators; a following '=' gives the two-character form.
                    logic [5:0] one;
                    unique case (mode_reg)
                        M_LT:    one = K_LT;
                        M_GT:    one = K_GT;
                        M_BANG:  one = K_NOT;
                        M_EQ:    one = K_ASSIGN;
                        M_PLUS:  one = K_ADD;
                        M_MINUS: one = K_SUB;
                        M_STAR:  one = K_MUL;
                        default: one = K_MOD;
                    endcase
                    if (c == "=") begin
                        if (tlen_next != '1) tlen_next = tlen_next + 1'b1;
                        res[0] = '{(mode_reg == M_EQ) ? K_EQEQ : one + 6'd1, tstart_reg,
                                   tlen_next, tline_reg, 1'b0};
                        res_cnt = 2'd1; mode_next = M_IDLE;
                    end else begin
                        res[0] = '{one, tstart_reg, tlen_reg, tline_reg, 1'b0};
                        res_cnt = 2'd1; mode_next = M_IDLE; consumed = 1'b0;
                    end
                end
                default: begin
                    mode_next = M_IDLE;
                    consumed  = 1'b0;
                end
            endcase

            // A byte not taken by a pending token starts a new token or an error, unless it is white space.
            if (!consumed && !halted_next && !(c == " " || (c >= 8'd9 && c <= 8'd13))) begin
                logic [5:0] single;
                logic       is_single;
                single    = K_SEMI;
                is_single = 1'b1;
                tstart_next = offset_reg;
                tlen_next   = LENGTH_BITS'(1);
                tline_next  = line_reg;
                case (c)
                    "(": single = K_LPAREN;
                    ")": single = K_RPAREN;
                    "{": single = K_LBRACE;
                    "}": single = K_RBRACE;
                    "[": single = K_LBRACK;
                    "]": single = K_RBRACK;
                    ";": single = K_SEMI;
                    default: is_single = 1'b0;
                endcase
                if (is_single) begin
                    res[res_cnt] = '{single, offset_reg, LENGTH_BITS'(1), line_reg, 1'b0};
                    res_cnt = res_cnt + 2'd1;
                    mode_next = M_IDLE;
                end else begin
                    case (c)
                        "/":   mode_next = M_SLASH;
                        "$":   mode_next = M_DOLLAR;
                        ".":   mode_next = M_FRAC;
                        8'h22: begin mode_next = M_STR; bslash_next = 1'b0; end
                        "<":   mode_next = M_LT;
                        ">":   mode_next = M_GT;
                        "!":   mode_next = M_BANG;
                        "=":   mode_next = M_EQ;
                        "|":   mode_next = M_BAR;
                        "&":   mode_next = M_AMP;
                        "+":   mode_next = M_PLUS;
                        "-":   mode_next = M_MINUS;
                        "*":   mode_next = M_STAR;
                        "%":   mode_next = M_PCT;
                        default: begin
                            if (is_digit(c)) begin
                                mode_next = M_DIGITS;
                            end else if (is_alpha(c) || c == "_") begin
                                mode_next = M_WORD;
                                for (int k = 0; k < KW_COUNT; k++) begin
                                    hits_next[k] = kw_match(k, '0, c);
                                end
                            end else begin
                                res[res_cnt] = '{K_ERR, offset_reg, '0, line_reg, 1'b1};
                                res_cnt = res_cnt + 2'd1;
                                halted_next = 1'b1;
                                mode_next = M_IDLE;
                            end
                        end
                    endcase
                end
            end

            if (c == 8'h0A) line_next = line_reg + 1'b1;
            offset_next = offset_reg + 1'b1;

            if (s_tlast && !halted_next) begin
                case (mode_next)
                    M_IDLE: ;
                    M_BCOM, M_BSTAR, M_DOLLAR, M_STR, M_BAR, M_AMP: begin
                        res[res_cnt] = '{K_ERR, tstart_next, '0, tline_next, 1'b1};
                        res_cnt = res_cnt + 2'd1;
                        halted_next = 1'b1;
                    end
                    default: begin
                        logic [5:0] fk;
                        case (mode_next)
                            M_SLASH:  fk = K_DIV;
                            M_LCOM:   fk = K_COMMENT;
                            M_NAME:   fk = K_NAME;
                            M_DIGITS: fk = K_INT;
                            M_FRAC:   fk = K_DEC;
                            M_LT:     fk = K_LT;
                            M_GT:     fk = K_GT;
                            M_BANG:   fk = K_NOT;
                            M_EQ:     fk = K_ASSIGN;
                            M_PLUS:   fk = K_ADD;
                            M_MINUS:  fk = K_SUB;
                            M_STAR:   fk = K_MUL;
                            M_PCT:    fk = K_MOD;
                            default:  fk = K_LABEL;
                        endcase
                        // A word closing here needs the hit mask after this byte.
                        if (mode_next == M_WORD) begin
                            for (int k = KW_COUNT - 1; k >= 0; k--) begin
                                if (hits_next[k] && LENGTH_BITS'(KW_LEN[k]) == tlen_next) begin
                                    fk = K_KW0 + 6'(k);
                                end
                            end
                        end
                        res[res_cnt] = '{fk, tstart_next, tlen_next, tline_next, 1'b0};
                        res_cnt = res_cnt + 2'd1;
                    end
                endcase
                if (!halted_next) begin
                    res[res_cnt] = '{K_END, offset_next, '0, line_next, 1'b1};
                    res_cnt = res_cnt + 2'd1;
                end
            end
        end

        // The end of a script returns every scanner register to its reset value; the result queue is left as it is.
        if (s_tlast) begin
            mode_next   = M_IDLE;
            offset_next = '0;
            tstart_next = '0;
            tlen_next   = '0;
            line_next   = LINE_BITS'(1);
            tline_next  = LINE_BITS'(1);
            hits_next   = '1;
            bslash_next = 1'b0;
            halted_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_IDLE;
            offset_reg <= '0;
            tstart_reg <= '0;
            tlen_reg   <= '0;
            line_reg   <= LINE_BITS'(1);
            tline_reg  <= LINE_BITS'(1);
            hits_reg   <= '1;
            bslash_reg <= 1'b0;
            halted_reg <= 1'b0;
            wr_reg     <= '0;
            rd_reg     <= '0;
            cnt_reg    <= '0;
        end else begin
            if (acc) begin
                mode_reg   <= mode_next;
                offset_reg <= offset_next;
                tstart_reg <= tstart_next;
                tlen_reg   <= tlen_next;
                line_reg   <= line_next;
                tline_reg  <= tline_next;
                hits_reg   <= hits_next;
                bslash_reg <= bslash_next;
                halted_reg <= halted_next;
                wr_reg     <= wr_reg + res_cnt;
            end
            if (pop) rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_reg + (acc ? {1'b0, res_cnt} : 3'd0) - {2'b00, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < res_cnt) q_reg[wr_reg + 2'(i)] <= res[i];
            end
        end
    end
endmodule

// File: rtl/stl_checker.sv
// Port checker for the script token lexer, bound to the top level.
`timescale 1ns / 1ps
module stl_checker
    import stl_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic        m_tlast
);
    // A result waiting for the sink keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    // Only the end marker and the error result close a script.
    a_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[5:0] == K_END || m_tdata[5:0] == K_ERR)
        else $error("final flag on an ordinary token");

    a_token: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[5:0] != K_END && m_tdata[5:0] != K_ERR)
        else $error("end or error result without final flag");

    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[53:38] == 16'd0)
        else $error("end or error result with a length");
endmodule

bind script_token_lexer stl_checker u_stl_checker (
    .aclk(aclk), .aresetn(aresetn),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
